### sv/mi_pkg.sv
// Shared widths, status codes and sequencer states for the modular inverse block.
`default_nettype none
package mi_pkg;

  localparam int WIDTH      = 32;
  localparam int CNT_W      = $clog2(WIDTH);
  localparam int IN_DATA_W  = ((2 * WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((WIDTH + 7) / 8) * 8;
  localparam int STATUS_W   = 2;

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_INVERSE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_MODULUS = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_POST,
    S_CHECK,
    S_FIX,
    S_NEG,
    S_FIN
  } state_t;

endpackage
`default_nettype wire

### sv/modular_inverse.sv
// Modular inverse by the extended Euclidean algorithm, one shared bit-serial divider.
//
// Each item (value, modulus) gives one result item: the inverse of value in
// 0..modulus-1 with status ok, or zero with status no-inverse (gcd not one) or
// bad-modulus (modulus below two). One shared shift-subtract divider produces
// one quotient bit per cycle; it runs once for the first reduction and once
// per Euclid step after it (at most 45 for 32-bit operands), and a bad
// modulus skips it. s_tready is high only while the sequencer idles; a
// finished result waits in the output register while the next item runs.
`default_nettype none
module modular_inverse (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 s_tvalid,
  output logic                                s_tready,
  input  wire [mi_pkg::IN_DATA_W-1:0]         s_tdata,   // value, modulus
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  output logic [mi_pkg::OUT_DATA_W-1:0]       m_tdata,   // inverse
  output logic [mi_pkg::STATUS_W-1:0]         m_tuser    // status
);
  import mi_pkg::*;

  state_t state, state_next;

  word_t  modr, r0, r1, u0, u1, p, d, acc, res;
  cnt_t   cnt;
  logic   neg0, neg1, first;
  logic [STATUS_W-1:0] status;

  word_t  in_value, in_modulus;
  word_t  p_step, acc_step;
  logic   in_fire, load_out, cnt_last;

  assign in_value   = s_tdata[WIDTH-1:0];
  assign in_modulus = s_tdata[2*WIDTH-1:WIDTH];

  mi_divstep u_divstep (
    .p_in    (p),
    .bit_in  (d[WIDTH-1]),
    .divisor (r1),
    .acc_in  (acc),
    .coef    (u1),
    .p_out   (p_step),
    .acc_out (acc_step)
  );

  assign cnt_last = (cnt == CNT_W'(WIDTH - 1));

  // outputs of the sequencer
  always_comb begin
    s_tready = (state == S_IDLE);
    in_fire  = s_tready && s_tvalid;
    load_out = (state == S_FIN) && (!m_tvalid || m_tready);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = (in_modulus < WIDTH'(2)) ? S_FIN : S_DIV;
        end
      end
      S_DIV:   if (cnt_last) state_next = S_POST;
      S_POST:  state_next = S_CHECK;
      S_CHECK: begin
        if (r1 != '0) begin
          state_next = S_DIV;
        end else begin
          state_next = (r0 != WIDTH'(1)) ? S_FIN : S_FIX;
        end
      end
      S_FIX:   state_next = S_NEG;
      S_NEG:   state_next = S_FIN;
      S_FIN:   if (load_out) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          modr   <= in_modulus;
          r1     <= in_modulus;
          d      <= in_value;
          p      <= '0;
          acc    <= '0;
          u1     <= '0;
          cnt    <= '0;
          first  <= 1'b1;
          res    <= '0;
          status <= ST_BAD_MODULUS;
        end
      end
      S_DIV: begin
        p   <= p_step;
        acc <= acc_step;
        d   <= {d[WIDTH-2:0], 1'b0};
        cnt <= cnt + CNT_W'(1);
      end
      S_POST: begin
        if (first) begin
          // value reduced modulo the modulus
          r0   <= modr;
          r1   <= p;
          u0   <= '0;
          u1   <= WIDTH'(1);
          neg0 <= 1'b0;
          neg1 <= 1'b0;
        end else begin
          r0   <= r1;
          r1   <= p;
          u0   <= u1;
          u1   <= acc + u0;
          neg0 <= neg1;
          neg1 <= ~neg1;
        end
      end
      S_CHECK: begin
        if (r1 != '0) begin
          d     <= r0;
          p     <= '0;
          acc   <= '0;
          cnt   <= '0;
          first <= 1'b0;
        end else begin
          res    <= '0;
          status <= ST_NO_INVERSE;
        end
      end
      S_FIX: begin
        if (u0 >= modr) u0 <= u0 - modr;
      end
      S_NEG: begin
        res    <= (neg0 && u0 != '0) ? modr - u0 : u0;
        status <= ST_OK;
      end
      S_FIN: ;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= OUT_DATA_W'(res);
      m_tuser <= status;
    end
  end

endmodule
`default_nettype wire

### sv/mi_divstep.sv
// One restoring-division step with a Horner accumulation of quotient times coefficient.
`default_nettype none
module mi_divstep (
  input  wire mi_pkg::word_t p_in,
  input  wire logic          bit_in,
  input  wire mi_pkg::word_t divisor,
  input  wire mi_pkg::word_t acc_in,
  input  wire mi_pkg::word_t coef,
  output mi_pkg::word_t      p_out,
  output mi_pkg::word_t      acc_out
);
  import mi_pkg::*;

  logic [WIDTH:0] trial;
  logic [WIDTH:0] diff;
  logic           qbit;

  always_comb begin
    trial   = {p_in, bit_in};
    diff    = trial - {1'b0, divisor};
    qbit    = ~diff[WIDTH];
    p_out   = qbit ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
    // acc holds the quotient prefix times coef, never above the modulus
    acc_out = {acc_in[WIDTH-2:0], 1'b0} + (qbit ? coef : '0);
  end

endmodule
`default_nettype wire
